>>> sv/lsir_pkg.sv
// shared types and constants of the indexed-removal lifo stack
package lsir_pkg;

    localparam int ID_W    = 32;
    localparam int NAME_W  = 64;
    localparam int ENTRY_W = ID_W + NAME_W;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_INVALID = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

endpackage

>>> sv/lsir_ram.sv
// generic single-write, single-read ram with registered read data
module lsir_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/lifo_stack_indexed_remove.sv
// bounded lifo stack of id and name entries with removal at a position and listing
//
// Input channel s_*: one command per transfer (push, pop top, remove at a 1-based
// position from the top, list). Result channel m_*: one result per command, or
// one per held entry for a non-empty list, with m_last on the final one. Every
// result carries status, entry count after the command and the current top entry.
// Entries live in one ram (one write and one registered read per cycle).
// Push, rejected commands and pops of the only entry go straight to the result;
// other pops and removal at position 1 first re-read the new top from the ram.
// Removal deeper down reads the removed entry, then one ram read-then-write per
// entry moved down. List streams one result per cycle while the receiver keeps up.
// The next command is taken once the last result of the previous one sits in
// the output register; a stalled receiver holds that register and, when a new
// result is due, holds the block. Reset (aresetn low at a clock edge) empties
// the stack and drops any pending result; ram contents need no clearing.
module lifo_stack_indexed_remove
    import lsir_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_op,
    input  logic [ID_W-1:0]                   s_plane_id,
    input  logic [NAME_W-1:0]                 s_name_tag,
    input  logic [$clog2(DEPTH+1)-1:0]        s_position,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic [ID_W-1:0]                   m_item_id,
    output logic [NAME_W-1:0]                 m_item_name,
    output logic [$clog2(DEPTH+1)-1:0]        m_entry_count,
    output logic [ID_W-1:0]                   m_top_id,
    output logic [NAME_W-1:0]                 m_top_name,
    output logic                              m_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOP_RD,
        ST_REM_RD,
        ST_SHIFT,
        ST_LIST,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [ID_W-1:0]     top_id_reg, top_id_next;
    logic [NAME_W-1:0]   top_name_reg, top_name_next;
    logic [AW-1:0]       idx_reg, idx_next;
    status_t             res_status_reg, res_status_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    logic [NAME_W-1:0]   res_name_reg, res_name_next;

    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [ID_W-1:0]     m_item_id_reg, m_item_id_next;
    logic [NAME_W-1:0]   m_item_name_reg, m_item_name_next;
    logic [CW-1:0]       m_count_reg, m_count_next;
    logic [ID_W-1:0]     m_top_id_reg, m_top_id_next;
    logic [NAME_W-1:0]   m_top_name_reg, m_top_name_next;
    logic                m_last_reg, m_last_next;

    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [ENTRY_W-1:0]  ram_wr_data;
    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;
    logic [ENTRY_W-1:0]  ram_rd_data;

    logic [CW-1:0]       cnt_m1;
    logic [CW-1:0]       cnt_m2;
    logic [CW-1:0]       rem_idx;
    logic                out_free;
    logic                do_pop;

    lsir_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign cnt_m1   = count_reg - CW'(1);
    assign cnt_m2   = count_reg - CW'(2);
    assign rem_idx  = count_reg - s_position;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        top_id_next      = top_id_reg;
        top_name_next    = top_name_reg;
        idx_next         = idx_reg;
        res_status_next  = res_status_reg;
        res_id_next      = res_id_reg;
        res_name_next    = res_name_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_item_id_next   = m_item_id_reg;
        m_item_name_next = m_item_name_reg;
        m_count_next     = m_count_reg;
        m_top_id_next    = m_top_id_reg;
        m_top_name_next  = m_top_name_reg;
        m_last_next      = m_last_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = count_reg[AW-1:0];
        ram_wr_data      = {s_plane_id, s_name_tag};
        ram_rd_en        = 1'b0;
        ram_rd_addr      = cnt_m1[AW-1:0];
        do_pop           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    res_status_next = STAT_OK;
                    res_id_next     = '0;
                    res_name_next   = '0;
                    state_next      = ST_EMIT;
                    unique case (op_t'(s_op))
                        OP_PUSH: begin
                            if (count_reg == CW'(DEPTH)) begin
                                res_status_next = STAT_FULL;
                            end else begin
                                ram_wr_en     = 1'b1;
                                count_next    = count_reg + CW'(1);
                                top_id_next   = s_plane_id;
                                top_name_next = s_name_tag;
                            end
                        end
                        OP_POP: begin
                            if (count_reg == '0) begin
                                res_status_next = STAT_EMPTY;
                            end else begin
                                do_pop = 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            priority if (count_reg == '0) begin
                                res_status_next = STAT_EMPTY;
                            end else if (s_position == '0 || s_position > count_reg) begin
                                res_status_next = STAT_INVALID;
                            end else if (s_position == CW'(1)) begin
                                do_pop = 1'b1;
                            end else begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = rem_idx[AW-1:0];
                                idx_next    = rem_idx[AW-1:0];
                                state_next  = ST_REM_RD;
                            end
                        end
                        OP_LIST: begin
                            if (count_reg == '0) begin
                                res_status_next = STAT_EMPTY;
                            end else begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = cnt_m1[AW-1:0];
                                idx_next    = cnt_m1[AW-1:0];
                                state_next  = ST_LIST;
                            end
                        end
                        default: begin
                            res_status_next = STAT_OK;
                        end
                    endcase
                    if (do_pop) begin
                        res_id_next   = top_id_reg;
                        res_name_next = top_name_reg;
                        count_next    = cnt_m1;
                        if (count_reg == CW'(1)) begin
                            top_id_next   = '0;
                            top_name_next = '0;
                        end else begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = cnt_m2[AW-1:0];
                            state_next  = ST_TOP_RD;
                        end
                    end
                end
            end
            ST_TOP_RD: begin
                top_id_next   = ram_rd_data[ENTRY_W-1 -: ID_W];
                top_name_next = ram_rd_data[NAME_W-1:0];
                state_next    = ST_EMIT;
            end
            ST_REM_RD: begin
                res_id_next   = ram_rd_data[ENTRY_W-1 -: ID_W];
                res_name_next = ram_rd_data[NAME_W-1:0];
                ram_rd_en     = 1'b1;
                ram_rd_addr   = idx_reg + AW'(1);
                state_next    = ST_SHIFT;
            end
            ST_SHIFT: begin
                // move the entry above down by one
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_reg;
                ram_wr_data = ram_rd_data;
                if (CW'(idx_reg) == cnt_m2) begin
                    count_next = cnt_m1;
                    state_next = ST_EMIT;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_reg + AW'(2);
                    idx_next    = idx_reg + AW'(1);
                end
            end
            ST_LIST: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_status_next    = STAT_OK;
                    m_item_id_next   = ram_rd_data[ENTRY_W-1 -: ID_W];
                    m_item_name_next = ram_rd_data[NAME_W-1:0];
                    m_count_next     = count_reg;
                    m_top_id_next    = top_id_reg;
                    m_top_name_next  = top_name_reg;
                    m_last_next      = (idx_reg == '0);
                    if (idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = idx_reg - AW'(1);
                        idx_next    = idx_reg - AW'(1);
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_status_next    = res_status_reg;
                    m_item_id_next   = res_id_reg;
                    m_item_name_next = res_name_reg;
                    m_count_next     = count_reg;
                    m_top_id_next    = top_id_reg;
                    m_top_name_next  = top_name_reg;
                    m_last_next      = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            top_id_reg   <= '0;
            top_name_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            top_id_reg   <= top_id_next;
            top_name_reg <= top_name_next;
            m_valid_reg  <= m_valid_next;
        end
        idx_reg         <= idx_next;
        res_status_reg  <= res_status_next;
        res_id_reg      <= res_id_next;
        res_name_reg    <= res_name_next;
        m_status_reg    <= m_status_next;
        m_item_id_reg   <= m_item_id_next;
        m_item_name_reg <= m_item_name_next;
        m_count_reg     <= m_count_next;
        m_top_id_reg    <= m_top_id_next;
        m_top_name_reg  <= m_top_name_next;
        m_last_reg      <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_item_id     = m_item_id_reg;
    assign m_item_name   = m_item_name_reg;
    assign m_entry_count = m_count_reg;
    assign m_top_id      = m_top_id_reg;
    assign m_top_name    = m_top_name_reg;
    assign m_last        = m_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_shift_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
        else $error("ram read and write hit the same entry");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STAT_FULL) |-> (m_entry_count == CW'(DEPTH)))
        else $error("full status with room left");

    a_empty_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_entry_count == '0) |-> (m_top_id == '0 && m_top_name == '0))
        else $error("empty stack reports a top entry");

endmodule

>>> tb/lsir_checker.sv
// result checker for the lifo stack: predicts each command's results and compares transfers
`timescale 1ns / 1ps

module lsir_checker
    import lsir_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [1:0]        s_op,
    input  logic [ID_W-1:0]   s_plane_id,
    input  logic [NAME_W-1:0] s_name_tag,
    input  logic [CW-1:0]     s_position,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [1:0]        m_status,
    input  logic [ID_W-1:0]   m_item_id,
    input  logic [NAME_W-1:0] m_item_name,
    input  logic [CW-1:0]     m_entry_count,
    input  logic [ID_W-1:0]   m_top_id,
    input  logic [NAME_W-1:0] m_top_name,
    input  logic              m_last,
    output int                error_count,
    output int                results_pending
);

    typedef struct {
        status_t           status;
        logic [ID_W-1:0]   item_id;
        logic [NAME_W-1:0] item_name;
        logic [CW-1:0]     entry_count;
        logic [ID_W-1:0]   top_id;
        logic [NAME_W-1:0] top_name;
        logic              last;
    } stack_result_t;

    logic [ID_W-1:0]   ids   [DEPTH];
    logic [NAME_W-1:0] names [DEPTH];
    int                held;
    stack_result_t     results_due [$];
    stack_result_t     want;

    initial begin
        error_count     = 0;
        results_pending = 0;
        held            = 0;
    end

    function automatic void post_result(status_t st, logic [ID_W-1:0] rid,
                                        logic [NAME_W-1:0] rname, logic is_last);
        stack_result_t r;
        r.status      = st;
        r.item_id     = rid;
        r.item_name   = rname;
        r.entry_count = held[CW-1:0];
        r.top_id      = (held > 0) ? ids[held-1] : '0;
        r.top_name    = (held > 0) ? names[held-1] : '0;
        r.last        = is_last;
        results_due.push_back(r);
    endfunction

    function automatic void apply_command(op_t op, logic [ID_W-1:0] pid,
                                          logic [NAME_W-1:0] tag, logic [CW-1:0] pos);
        logic [ID_W-1:0]   rid;
        logic [NAME_W-1:0] rname;
        int                slot;
        case (op)
            OP_PUSH: begin
                if (held >= DEPTH) begin
                    post_result(STAT_FULL, '0, '0, 1'b1);
                end else begin
                    ids[held]   = pid;
                    names[held] = tag;
                    held++;
                    post_result(STAT_OK, '0, '0, 1'b1);
                end
            end
            OP_POP: begin
                if (held == 0) begin
                    post_result(STAT_EMPTY, '0, '0, 1'b1);
                end else begin
                    rid   = ids[held-1];
                    rname = names[held-1];
                    held--;
                    post_result(STAT_OK, rid, rname, 1'b1);
                end
            end
            OP_REMOVE: begin
                if (held == 0) begin
                    post_result(STAT_EMPTY, '0, '0, 1'b1);
                end else if (pos == 0 || int'(pos) > held) begin
                    post_result(STAT_INVALID, '0, '0, 1'b1);
                end else begin
                    slot  = held - int'(pos);
                    rid   = ids[slot];
                    rname = names[slot];
                    // entries above the removed one slide down, keeping their order
                    for (int i = slot; i < held - 1; i++) begin
                        ids[i]   = ids[i+1];
                        names[i] = names[i+1];
                    end
                    held--;
                    post_result(STAT_OK, rid, rname, 1'b1);
                end
            end
            default: begin
                if (held == 0) begin
                    post_result(STAT_EMPTY, '0, '0, 1'b1);
                end else begin
                    for (int i = held - 1; i >= 0; i--) begin
                        post_result(STAT_OK, ids[i], names[i], i == 0);
                    end
                end
            end
        endcase
    endfunction

    function automatic void check_field(string field, logic [NAME_W-1:0] want_val,
                                        logic [NAME_W-1:0] got_val);
        if (got_val !== want_val) begin
            $error("%s: expected %0h, got %0h", field, want_val, got_val);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            held = 0;
            results_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $error("result transfer with no result outstanding");
                    error_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("status", want.status, m_status);
                    check_field("item_id", want.item_id, m_item_id);
                    check_field("item_name", want.item_name, m_item_name);
                    check_field("entry_count", want.entry_count, m_entry_count);
                    check_field("top_id", want.top_id, m_top_id);
                    check_field("top_name", want.top_name, m_top_name);
                    check_field("last", want.last, m_last);
                end
            end
            if (s_valid && s_ready) begin
                apply_command(op_t'(s_op), s_plane_id, s_name_tag, s_position);
            end
        end
        results_pending = results_due.size();
    end

endmodule

>>> tb/tb_top.sv
// testbench top for the lifo stack: clock, reset, command stimulus, receiver stalls, verdict
`timescale 1ns / 1ps

module tb_top;
    import lsir_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CW          = $clog2(DEPTH + 1);
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 80;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_op = OP_PUSH;
    logic [ID_W-1:0]   s_plane_id = '0;
    logic [NAME_W-1:0] s_name_tag = '0;
    logic [CW-1:0]     s_position = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [1:0]        m_status;
    logic [ID_W-1:0]   m_item_id;
    logic [NAME_W-1:0] m_item_name;
    logic [CW-1:0]     m_entry_count;
    logic [ID_W-1:0]   m_top_id;
    logic [NAME_W-1:0] m_top_name;
    logic              m_last;

    int error_count;
    int results_pending;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int stack_level = 0;
    int stack_goal = 0;
    logic hold_request = 1'b0;
    logic holding = 1'b0;

    lifo_stack_indexed_remove #(.DEPTH(DEPTH)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_plane_id    (s_plane_id),
        .s_name_tag    (s_name_tag),
        .s_position    (s_position),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_item_id     (m_item_id),
        .m_item_name   (m_item_name),
        .m_entry_count (m_entry_count),
        .m_top_id      (m_top_id),
        .m_top_name    (m_top_name),
        .m_last        (m_last)
    );

    lsir_checker #(.DEPTH(DEPTH)) stack_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_plane_id      (s_plane_id),
        .s_name_tag      (s_name_tag),
        .s_position      (s_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_item_id       (m_item_id),
        .m_item_name     (m_item_name),
        .m_entry_count   (m_entry_count),
        .m_top_id        (m_top_id),
        .m_top_name      (m_top_name),
        .m_last          (m_last),
        .error_count     (error_count),
        .results_pending (results_pending)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("lifo_stack_indexed_remove: mismatch");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end

    // long receiver hold-off so the output backs up and the input stalls
    initial begin
        wait (hold_request);
        @(posedge aclk);
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        holding = 1'b0;
    end

    task automatic send_command(input op_t op, input logic [ID_W-1:0] pid,
                                input logic [NAME_W-1:0] tag, input logic [CW-1:0] pos);
        @(negedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid    <= 1'b1;
        s_op       <= op;
        s_plane_id <= pid;
        s_name_tag <= tag;
        s_position <= pos;
        do @(posedge aclk); while (!s_ready);
        case (op)
            OP_PUSH:   if (stack_level < DEPTH) stack_level++;
            OP_POP:    if (stack_level > 0) stack_level--;
            OP_REMOVE: if (pos != 0 && int'(pos) <= stack_level) stack_level--;
            default:   ;
        endcase
    endtask

    task automatic random_command();
        int               r;
        op_t              op;
        logic [CW-1:0]    pos;
        r = $urandom_range(99);
        if (r < 12) begin
            op = OP_LIST;
        end else if (r < 20) begin
            op = op_t'($urandom_range(3));
        end else if (stack_level < stack_goal) begin
            op = OP_PUSH;
        end else if (stack_level > stack_goal) begin
            op = ($urandom_range(2) == 0) ? OP_POP : OP_REMOVE;
        end else begin
            op = ($urandom_range(1) == 0) ? OP_PUSH : OP_REMOVE;
        end
        if (stack_level > 0 && $urandom_range(9) != 0) begin
            pos = CW'($urandom_range(stack_level, 1));
        end else begin
            pos = CW'($urandom_range((1 << CW) - 1));
        end
        send_command(op, $urandom, {$urandom, $urandom}, pos);
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // empty stack: list, pop and remove all report empty
        send_command(OP_LIST, '0, '0, 5'd1);
        send_command(OP_POP, '0, '0, 5'd1);
        send_command(OP_REMOVE, '1, '1, 5'd1);
        // fill to full, extremes first
        send_command(OP_PUSH, '0, '0, '0);
        send_command(OP_PUSH, '1, '1, '1);
        for (int i = 2; i < DEPTH; i++) begin
            send_command(OP_PUSH, $urandom, {$urandom, $urandom}, '0);
        end
        send_command(OP_PUSH, 32'h5a5a_a5a5, 64'hdead_beef_0123_4567, '0);
        send_command(OP_LIST, '0, '0, '0);
        send_command(OP_REMOVE, '0, '0, 5'd0);
        send_command(OP_REMOVE, '0, '0, 5'd31);
        send_command(OP_REMOVE, '0, '0, 5'd16);
        send_command(OP_REMOVE, '0, '0, 5'd1);
        send_command(OP_POP, '0, '0, '0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            if (phase == 0) hold_request = 1'b1;
            for (int n = 0; n < 46; n++) begin
                if (n % 10 == 0) begin
                    stack_goal = ($urandom_range(3) == 0) ?
                                 (($urandom_range(1) == 0) ? 0 : DEPTH) :
                                 $urandom_range(DEPTH);
                end
                random_command();
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        recv_stall_pct = 0;
        wait (results_pending == 0);
        repeat (40) @(posedge aclk);
        if (error_count == 0) begin
            $display("lifo_stack_indexed_remove: match");
        end else begin
            $display("lifo_stack_indexed_remove: mismatch");
        end
        $finish;
    end

endmodule

>>> lifo_stack_indexed_remove.f
sv/lsir_pkg.sv
sv/lsir_ram.sv
sv/lifo_stack_indexed_remove.sv
tb/lsir_checker.sv
tb/tb_top.sv
